@@ rtl/assert_macros.svh @@
// Assertion macros used by the back end (tsfm_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)
`endif

@@ rtl/tsfm_pkg.sv @@
// Shared types and constants of the timeline to source frame mapper.
package tsfm_pkg;
  localparam int MARKER_SLOTS = 64;
  localparam int IDX_W = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;
  localparam int FILL_W = $clog2(MARKER_SLOTS + 1);
  localparam int FRAME_W = 24;
  localparam int FPS_W = 18;
  localparam int RATE_W = 14;
  localparam int COUNT_W = 16;
  localparam int MILLI = 1000;
  localparam int ADJ_W = FRAME_W + 1;
  localparam int RS_W = RATE_W + FPS_W;
  localparam int NUM_W = ADJ_W + RS_W;
  localparam int DEN_W = FPS_W + 10;
  localparam int JOBQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_CLIP_START   = 3'd0,
    CFG_CLIP_DUR     = 3'd1,
    CFG_SRC_IN       = 3'd2,
    CFG_SRC_DUR      = 3'd3,
    CFG_SRC_FPS      = 3'd4,
    CFG_TL_FPS       = 3'd5,
    CFG_PLAY_RATE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_CMP,
    BK_CUM,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [FRAME_W-1:0] clip_start;
    logic [FRAME_W-1:0] clip_dur;
    logic [FRAME_W-1:0] src_in;
    logic [FRAME_W-1:0] src_dur;
    logic [FPS_W-1:0]   src_fps;
    logic [FPS_W-1:0]   tl_fps;
    logic [RATE_W-1:0]  play_rate;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FRAME_W-1:0] timeline_frame;
    logic [FRAME_W-1:0] marker_frame;
    logic [COUNT_W-1:0] marker_count;
    logic               marker_duplicate;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] source_frame;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    cmd_e               op;
    logic [FRAME_W-1:0] local_frame;
    logic [FRAME_W-1:0] probe;
    logic [FRAME_W-1:0] mframe;
    logic [COUNT_W-1:0] mcount;
    logic               mdup;
  } job_t;
endpackage

@@ rtl/tsfm_front.sv @@
// Front end: decodes the command and clamps the query position into the clip.
module tsfm_front import tsfm_pkg::*; (
  input  in_item_t           in_i,
  input  logic               push_i,
  input  logic [FRAME_W-1:0] clip_start_i,
  input  logic [FRAME_W-1:0] clip_dur_i,
  input  logic               q_full_i,
  output logic               q_wr_o,
  output job_t               job_o
);
  logic [FRAME_W-1:0] rel, max_local, local_frame;

  always_comb begin
    rel = (in_i.timeline_frame > clip_start_i) ? (in_i.timeline_frame - clip_start_i)
                                               : '0;
    max_local = (clip_dur_i != '0) ? (clip_dur_i - FRAME_W'(1)) : '0;
    local_frame = (rel > max_local) ? max_local : rel;
  end

  always_comb begin
    job_o.op = cmd_e'(in_i.cmd);
    job_o.local_frame = local_frame;
    job_o.probe = clip_start_i + local_frame;
    job_o.mframe = in_i.marker_frame;
    job_o.mcount = (in_i.marker_count == '0) ? COUNT_W'(1) : in_i.marker_count;
    job_o.mdup = in_i.marker_duplicate;
  end

  assign q_wr_o = push_i && !q_full_i;
endmodule

@@ rtl/tsfm_jobq.sv @@
// Short job queue between the front end and the back end.
module tsfm_jobq import tsfm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output job_t rdata_o,
  output logic empty_o
);
  localparam int PTR_W = $clog2(JOBQ_DEPTH);
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t              slots_q [JOBQ_DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) slots_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= (wptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      if (rd_i) rptr_q <= (rptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      if (wr_i && !rd_i) cnt_q <= cnt_q + CNT_W'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end
endmodule

@@ rtl/tsfm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tsfm_div import tsfm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             take;

  always_comb begin
    trial = {rem_q, n_q[NUM_W-1]};
    take  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      n_q   <= {n_q[NUM_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;
endmodule

@@ rtl/tsfm_back.sv @@
// Back end: marker table, binary search, scaling and the result register.
`include "assert_macros.svh"
module tsfm_back import tsfm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  job_t      job_i,
  output logic      q_rd_o,
  output out_item_t out_o,
  output logic      empty_o,
  input  logic      pop_i
);
  localparam int SUM_W = NUM_W + 1;

  // marker table: {frame, cumulative delta}
  logic [2*FRAME_W-1:0] mem_q [MARKER_SLOTS];
  logic [2*FRAME_W-1:0] rdata_q;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;

  back_state_e state_q, state_d;
  logic [FILL_W-1:0]  fill_q, fill_d, lo_q, lo_d, hi_q, hi_d, mid, prev;
  logic signed [FRAME_W-1:0] delta_q, delta_d;
  logic [FRAME_W-1:0] last_q, last_d;
  logic [FRAME_W-1:0] local_q, local_d, probe_q, probe_d;
  logic [RS_W-1:0]    rs_q, rs_d;
  logic [ADJ_W-1:0]   adj_q, adj_d;
  logic [NUM_W-1:0]   num_q, num_d;
  out_item_t          res_q, res_d, out_q;
  logic               ovalid_q;
  logic               div_go_q;
  logic               div_start, div_done, load_out;
  logic [NUM_W-1:0]   quot;
  logic [DEN_W-1:0]   den;
  logic [RATE_W-1:0]  rate1;
  logic [FPS_W-1:0]   sfps1, tfps1;
  logic signed [FRAME_W+1:0] run_sum, adj_s;
  logic [SUM_W-1:0]   rsum;
  logic [FRAME_W-1:0] src_hi;

  assign rate1 = (cfg_i.play_rate == '0) ? RATE_W'(1) : cfg_i.play_rate;
  assign sfps1 = (cfg_i.src_fps == '0) ? FPS_W'(1) : cfg_i.src_fps;
  assign tfps1 = (cfg_i.tl_fps == '0) ? FPS_W'(1) : cfg_i.tl_fps;
  assign den   = DEN_W'(tfps1 * DEN_W'(MILLI));

  tsfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[fill_q[IDX_W-1:0]] <= {job_i.mframe, delta_d};
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    lo_d = lo_q;
    hi_d = hi_q;
    delta_d = delta_q;
    last_d = last_q;
    local_d = local_q;
    probe_d = probe_q;
    rs_d = rs_q;
    adj_d = adj_q;
    num_d = num_q;
    res_d = res_q;
    q_rd_o = 1'b0;
    mem_we = 1'b0;
    load_out = 1'b0;
    mid = FILL_W'((lo_q + hi_q) >> 1);
    prev = lo_q - FILL_W'(1);
    rd_addr = mid[IDX_W-1:0];
    run_sum = $signed({{2{delta_q[FRAME_W-1]}}, delta_q})
            + (job_i.mdup ? -$signed({2'b00, job_i.mcount}) : $signed({2'b00, job_i.mcount}));
    adj_s = $signed({2'b00, local_q})
          + $signed({{2{rdata_q[FRAME_W-1]}}, rdata_q[FRAME_W-1:0]});
    src_hi = (cfg_i.src_dur != '0) ? (cfg_i.src_dur - FRAME_W'(1)) : '0;
    rsum = SUM_W'(cfg_i.src_in) + SUM_W'(quot);

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o = 1'b1;
          res_d.source_frame = '0;
          res_d.status = ST_OK;
          state_d = BK_DONE;
          case (job_i.op)
            CMD_QUERY: begin
              local_d = job_i.local_frame;
              probe_d = job_i.probe;
              lo_d = '0;
              hi_d = fill_q;
              rs_d = RS_W'(rate1) * RS_W'(sfps1);
              state_d = BK_SEARCH;
            end
            CMD_APPEND: begin
              if (fill_q >= FILL_W'(MARKER_SLOTS)) begin
                res_d.status = ST_FULL;
              end else if (fill_q != '0 && job_i.mframe < last_q) begin
                res_d.status = ST_ORDER;
              end else begin
                // saturate at the signed delta range
                if (run_sum > $signed({3'b000, {(FRAME_W-1){1'b1}}}))
                  delta_d = {1'b0, {(FRAME_W-1){1'b1}}};
                else if (run_sum < -$signed({3'b001, {(FRAME_W-1){1'b0}}}))
                  delta_d = {1'b1, {(FRAME_W-1){1'b0}}};
                else
                  delta_d = run_sum[FRAME_W-1:0];
                mem_we = 1'b1;
                last_d = job_i.mframe;
                fill_d = fill_q + FILL_W'(1);
              end
            end
            CMD_CLEAR: begin
              fill_d = '0;
              delta_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_SEARCH: begin
        if (lo_q < hi_q) begin
          state_d = BK_CMP;
        end else if (lo_q != '0) begin
          rd_addr = prev[IDX_W-1:0];
          state_d = BK_CUM;
        end else begin
          adj_d = ADJ_W'(local_q);
          state_d = BK_MUL;
        end
      end
      BK_CMP: begin
        if (rdata_q[2*FRAME_W-1:FRAME_W] < probe_q) lo_d = mid + FILL_W'(1);
        else hi_d = mid;
        state_d = BK_SEARCH;
      end
      BK_CUM: begin
        // floor at zero
        adj_d = adj_s[FRAME_W+1] ? '0 : adj_s[ADJ_W-1:0];
        state_d = BK_MUL;
      end
      BK_MUL: begin
        num_d = NUM_W'(adj_q) * NUM_W'(rs_q);
        state_d = BK_DIV;
      end
      BK_DIV: begin
        // done still shows the previous quotient in the launch cycle
        if (div_done && !div_start) begin
          res_d.source_frame = (rsum > SUM_W'(src_hi)) ? src_hi : rsum[FRAME_W-1:0];
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ovalid_q || pop_i) begin
          load_out = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // launch the divider from a register set in BK_MUL, while num_q holds the product
  assign div_start = div_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      fill_q   <= '0;
      delta_q  <= '0;
      ovalid_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      delta_q  <= delta_d;
      div_go_q <= (state_q == BK_MUL);
      if (load_out) ovalid_q <= 1'b1;
      else if (pop_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    last_q  <= last_d;
    local_q <= local_d;
    probe_q <= probe_d;
    rs_q    <= rs_d;
    adj_q   <= adj_d;
    num_q   <= num_d;
    res_q   <= res_d;
    if (load_out) out_q <= res_q;
  end

  assign out_o   = out_q;
  assign empty_o = !ovalid_q;

  `ASSERT_NEVER(a_fill_range, fill_q > FILL_W'(MARKER_SLOTS), "marker fill past table size")
  `ASSERT_CLK(a_status_zero, ovalid_q && out_q.status != ST_OK |-> out_q.source_frame == '0,
              "failed append carries a frame")
  `ASSERT_CLK(a_search_bounds, state_q == BK_CMP |-> lo_q < hi_q && hi_q <= fill_q,
              "search window out of bounds")
endmodule

@@ rtl/timeline_to_source_frame_map_unit.sv @@
// Top level of the timeline to source frame mapper.
// Input channel: drive in_i and raise push; a beat is taken when push is high
// and full is low. cmd selects query, marker append or table clear.
// Result channel: one result beat per input beat, in order, shown on out_o
// while empty is low and taken when pop is high.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once;
// write only while no beat is in flight.
// Processing: an append, clear or unused command is dequeued and its result
// loaded. A query runs a binary search over the filled markers of the 64-entry
// table, then the delta, product and bit-serial divider, and the result load.
// The back end handles one beat at a time; a two-entry job queue keeps taking
// beats meanwhile.
// When pop stays low the finished result holds in the output register and the
// back end holds its next result; the queue then fills and full rises.
// Reset empties the marker table and queue and restores the default rates.
module timeline_to_source_frame_map_unit import tsfm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_item_t             in_i,
  input  logic                 push,
  output logic                 full,
  output out_item_t            out_o,
  output logic                 empty,
  input  logic                 pop,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [FRAME_W-1:0]   cfg_wdata_i
);
  cfg_t cfg_q;
  job_t job_w, job_r;
  logic q_wr, q_rd, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_start <= '0;
      cfg_q.clip_dur   <= '0;
      cfg_q.src_in     <= '0;
      cfg_q.src_dur    <= '0;
      cfg_q.src_fps    <= FPS_W'(30000);
      cfg_q.tl_fps     <= FPS_W'(30000);
      cfg_q.play_rate  <= RATE_W'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CLIP_START: cfg_q.clip_start <= cfg_wdata_i;
        CFG_CLIP_DUR:   cfg_q.clip_dur   <= cfg_wdata_i;
        CFG_SRC_IN:     cfg_q.src_in     <= cfg_wdata_i;
        CFG_SRC_DUR:    cfg_q.src_dur    <= cfg_wdata_i;
        CFG_SRC_FPS:    cfg_q.src_fps    <= cfg_wdata_i[FPS_W-1:0];
        CFG_TL_FPS:     cfg_q.tl_fps     <= cfg_wdata_i[FPS_W-1:0];
        CFG_PLAY_RATE:  cfg_q.play_rate  <= cfg_wdata_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  tsfm_front u_front (
    .in_i        (in_i),
    .push_i      (push),
    .clip_start_i(cfg_q.clip_start),
    .clip_dur_i  (cfg_q.clip_dur),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .job_o       (job_w)
  );

  tsfm_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .wdata_i(job_w),
    .full_o (q_full),
    .rd_i   (q_rd),
    .rdata_o(job_r),
    .empty_o(q_empty)
  );

  tsfm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_empty_i(q_empty),
    .job_i    (job_r),
    .q_rd_o   (q_rd),
    .out_o    (out_o),
    .empty_o  (empty),
    .pop_i    (pop)
  );

  assign full = q_full;
endmodule
